/* design/iwr_pkg.sv */
// ----------------------------------------------------------------------------
// Interpolating wavetable read: shared package
// Widths, command codes and the operation record passed from the front end
// through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package iwr_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_BITS    = 12;
    localparam int POS_BITS    = 29;

    // Default table depth and the depth of the front-to-back queue.
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int QUEUE_DEPTH     = 2;

    // Reset value of the last valid index register.
    localparam logic [IDX_BITS-1:0] LAST_INDEX_RESET = '1;

    // Command codes carried by an input item.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Classified operation kinds.
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_MISS
    } op_kind_t;

    // One queued operation.
    typedef struct packed {
        op_kind_t                       kind;
        logic [IDX_BITS-1:0]            idx;
        logic [FRAC_BITS-1:0]           frac;
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic                           a_oob;
        logic                           b_oob;
    } op_t;

endpackage

`default_nettype wire

/* design/iwr_if.sv */
// ----------------------------------------------------------------------------
// Interpolating wavetable read: channel interfaces
// Valid/ready channels for input items, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface iwr_item_if;
    import iwr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [IDX_BITS-1:0]            write_addr;
    logic signed [SAMPLE_BITS-1:0]  write_sample;
    logic signed [POS_BITS-1:0]     read_position;

    modport source (
        output valid, cmd, write_addr, write_sample, read_position,
        input  ready
    );
    modport sink (
        input  valid, cmd, write_addr, write_sample, read_position,
        output ready
    );
endinterface

interface iwr_result_if;
    import iwr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_BITS-1:0]  sample_out;
    logic                           in_range;

    modport source (
        output valid, sample_out, in_range,
        input  ready
    );
    modport sink (
        input  valid, sample_out, in_range,
        output ready
    );
endinterface

interface iwr_cfg_if;
    import iwr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [IDX_BITS-1:0]    last_index;

    modport source (
        output valid, last_index,
        input  ready
    );
    modport sink (
        input  valid, last_index,
        output ready
    );
endinterface

`default_nettype wire

/* design/iwr_front.sv */
// ----------------------------------------------------------------------------
// Interpolating wavetable read: front end
// Holds the last index register, accepts items and classifies them into
// table writes, interpolated reads and out-of-range misses.
// ----------------------------------------------------------------------------
`default_nettype none

module iwr_front #(
    parameter int TABLE_DEPTH = iwr_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    iwr_item_if.sink    item,
    iwr_cfg_if.sink     cfg,
    output iwr_pkg::op_t push_data,
    output logic        push_valid,
    input  wire logic   push_ready
);
    import iwr_pkg::*;

    localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

    logic [IDX_BITS-1:0]            last_index_reg;
    logic [POS_BITS-2:0]            limit;
    logic [IDX_BITS-1:0]            pos_idx;
    logic                           pos_miss;
    logic                           write_keep;
    op_t                            op;

    // Configuration register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= LAST_INDEX_RESET;
        end
        else if (cfg.valid)
        begin
            last_index_reg <= cfg.last_index;
        end
    end

    // Range check: negative, or beyond the last index in Q12.16.
    assign limit    = {last_index_reg, {FRAC_BITS{1'b0}}};
    assign pos_miss = item.read_position[POS_BITS-1]
                      || (item.read_position[POS_BITS-2:0] > limit);
    assign pos_idx  = item.read_position[POS_BITS-2:FRAC_BITS];

    // Writes beyond the table are accepted and dropped.
    assign write_keep = (32'(item.write_addr) < DEPTH_U);

    // Build the operation record. On an exact index the right neighbour is
    // not used at all, so it is masked like an entry beyond the table.
    always_comb
    begin
        op        = '0;
        op.sample = item.write_sample;
        if (item.cmd == CMD_WRITE)
        begin
            op.kind = OP_WRITE;
            op.idx  = item.write_addr;
        end
        else if (pos_miss)
        begin
            op.kind = OP_MISS;
        end
        else
        begin
            op.kind  = OP_READ;
            op.idx   = pos_idx;
            op.frac  = item.read_position[FRAC_BITS-1:0];
            op.a_oob = (32'(pos_idx) >= DEPTH_U);
            op.b_oob = (item.read_position[FRAC_BITS-1:0] == '0)
                       || ((32'(pos_idx) + 32'd1) >= DEPTH_U);
        end
    end

    assign item.ready = push_ready;
    assign push_data  = op;
    assign push_valid = item.valid && ((item.cmd == CMD_READ) || write_keep);

endmodule

`default_nettype wire

/* design/iwr_queue.sv */
// ----------------------------------------------------------------------------
// Interpolating wavetable read: operation queue
// A short first-in first-out buffer that decouples the front end from the
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module iwr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire iwr_pkg::op_t   push_data,
    input  wire logic           push_valid,
    output logic                push_ready,
    output iwr_pkg::op_t        q_data,
    output logic                q_valid,
    input  wire logic           pop
);
    import iwr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = push_valid && push_ready;
    assign q_valid    = (count_reg != '0);
    assign q_data     = entry_reg[rd_ptr_reg];

    // Storage for queued operations.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // A push without a pop grows the count by exactly one.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    // The back end never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

/* design/iwr_back.sv */
// ----------------------------------------------------------------------------
// Interpolating wavetable read: back end
// Owns the single-port sample memory, carries out writes and interpolated
// reads from the queue and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iwr_back #(
    parameter int TABLE_DEPTH = iwr_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire iwr_pkg::op_t   q_data,
    input  wire logic           q_valid,
    output logic                pop,
    iwr_result_if.source        result
);
    import iwr_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH_B,
        S_MUL,
        S_SUM
    } state_t;

    state_t                         state_reg;
    op_t                            op_reg;
    logic signed [SAMPLE_BITS-1:0]  a_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  out_sample_reg;
    logic                           out_in_range_reg;

    logic signed [SAMPLE_BITS-1:0]  sample_mem [TABLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]              mem_addr;
    logic                           mem_we;
    logic [IDX_BITS:0]              idx_plus;

    logic                           out_free;
    logic                           out_load;
    logic signed [SAMPLE_BITS-1:0]  a_val;
    logic signed [SAMPLE_BITS-1:0]  b_val;
    logic signed [SAMPLE_BITS:0]    diff;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_shift;
    logic signed [SAMPLE_BITS:0]    sum;

    assign out_free = !out_valid_reg || result.ready;

    // A result is loaded for a miss taken while idle or for a finished read.
    assign out_load = ((state_reg == S_IDLE) && q_valid && (q_data.kind == OP_MISS)
                       && out_free)
                      || ((state_reg == S_SUM) && out_free);

    // Pop when idle; a miss also needs the result register free.
    assign pop    = (state_reg == S_IDLE) && q_valid
                    && ((q_data.kind != OP_MISS) || out_free);
    assign mem_we = (state_reg == S_IDLE) && q_valid && (q_data.kind == OP_WRITE);

    // Memory address: the left neighbour when idle, the right one afterwards.
    assign idx_plus = {1'b0, op_reg.idx} + 1'b1;
    assign mem_addr = (state_reg == S_IDLE) ? ADDR_W'(q_data.idx) : ADDR_W'(idx_plus);

    // Single-port sample memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_addr] <= q_data.sample;
        end
        rd_data_reg <= sample_mem[mem_addr];
    end

    // Interpolation datapath: difference times fraction, then floor shift.
    assign a_val      = op_reg.a_oob ? '0 : rd_data_reg;
    assign b_val      = op_reg.b_oob ? '0 : rd_data_reg;
    assign diff       = {b_val[SAMPLE_BITS-1], b_val} - {a_reg[SAMPLE_BITS-1], a_reg};
    assign prod_next  = diff * $signed({1'b0, op_reg.frac});
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign sum        = {a_reg[SAMPLE_BITS-1], a_reg} + $signed(prod_shift[SAMPLE_BITS:0]);

    // Sequencer with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= '0;
            a_reg            <= '0;
            prod_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_sample_reg   <= '0;
            out_in_range_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && (q_data.kind == OP_READ))
                    begin
                        op_reg    <= q_data;
                        state_reg <= S_FETCH_B;
                    end
                    else if (q_valid && (q_data.kind == OP_MISS) && out_free)
                    begin
                        out_sample_reg   <= '0;
                        out_in_range_reg <= 1'b0;
                    end
                end
                S_FETCH_B:
                begin
                    a_reg     <= a_val;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (out_free)
                    begin
                        out_sample_reg   <= sum[SAMPLE_BITS-1:0];
                        out_in_range_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.in_range   = out_in_range_reg;

    // The multiply step always follows the right-neighbour fetch.
    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> $past(state_reg) == S_FETCH_B)
        else $error("multiply step entered out of order");

    // An out-of-range result carries a zero sample.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.in_range |-> result.sample_out == '0)
        else $error("out-of-range result with nonzero sample");

    // A finished read waits while the result register is occupied.
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM && !out_free |=> state_reg == S_SUM)
        else $error("finished read left before the result was taken");

endmodule

`default_nettype wire

/* design/interpolating_wavetable_read.sv */
// ----------------------------------------------------------------------------
// Interpolating wavetable read: top level
// Sample table written one entry at a time and read at a Q12.16 position
// with linear interpolation between neighbouring entries.
// ----------------------------------------------------------------------------
// Use:
//   item   - input transfers. cmd selects a table write (write_addr,
//            write_sample; no result) or an interpolated read (read_position;
//            exactly one result).
//   result - one transfer per read: sample_out and in_range. A position that
//            is negative or beyond last_index gives zero with in_range clear.
//   cfg    - write of last_index, taken in any cycle; write it while idle.
// Flow:
//   An in-range read takes two accesses to the single-port sample memory,
//   one multiply stage and one add stage, and keeps the back end busy until
//   its result is loaded; the add stage waits while the result register is
//   occupied. Writes and out-of-range reads are handled in the idle state.
//   A two-entry queue sits between front and back, so items keep being taken
//   while a result waits; when the receiver stalls the result register holds,
//   the queue fills and then item.ready drops.
// Reset:
//   last_index returns to 4095 and the queue empties. Table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolating_wavetable_read #(
    parameter int TABLE_DEPTH = iwr_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    iwr_item_if.sink        item,
    iwr_result_if.source    result,
    iwr_cfg_if.sink         cfg
);
    import iwr_pkg::*;

    op_t    push_data;
    logic   push_valid;
    logic   push_ready;
    op_t    q_data;
    logic   q_valid;
    logic   pop;

    // Front end: configuration and classification.
    iwr_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Queue between front and back.
    iwr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .q_data     (q_data),
        .q_valid    (q_valid),
        .pop        (pop)
    );

    // Back end: memory, interpolation and result register.
    iwr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolating wavetable read: testbench
// Fills the sample table, reads it back at fractional positions and checks
// each result against an interpolation computed alongside, under random
// stalls on both channels and several settings of the last valid index.
// ----------------------------------------------------------------------------

module tb_top;
    import iwr_pkg::*;

    // Cycles allowed for writes still queued in the block after the last result.
    localparam int DRAIN_CYCLES    = 16;
    // Bound on the wait for outstanding results at the end of the run.
    localparam int END_WAIT_CYCLES = 4000;
    localparam int IDLE_PERCENT    = 28;
    localparam int MAX_REPORTS     = 10;

    // One expected read result.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          in_range;
    } lookup_t;

    logic clk;
    logic rst_n;

    iwr_item_if   item_bus ();
    iwr_result_if result_bus ();
    iwr_cfg_if    cfg_bus ();

    interpolating_wavetable_read DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Copy of the table and the index register as the block should hold them.
    logic signed [SAMPLE_BITS-1:0] shadow_table [TABLE_DEPTH_DEF];
    bit                            shadow_written [TABLE_DEPTH_DEF];
    logic [IDX_BITS-1:0]           shadow_last_index;

    lookup_t pending_lookups [$];
    lookup_t oldest_lookup;
    int      error_count;
    int      items_sent;
    bit      steady;

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the length of the run.
    initial
    begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Records a failure; only the first few are described.
    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("tb_top: %s", msg);
    endfunction

    // Expected result of a read at the given Q12.16 position.
    function automatic lookup_t interpolate_lookup(input logic signed [POS_BITS-1:0] pos);
        lookup_t              res;
        logic [POS_BITS-1:0]  limit;
        logic [IDX_BITS-1:0]  idx;
        logic [FRAC_BITS-1:0] frac;
        longint               lo;
        longint               hi;
        longint               prod;
        limit = {1'b0, shadow_last_index, {FRAC_BITS{1'b0}}};
        if (pos[POS_BITS-1] || $unsigned(pos) > limit)
        begin
            res.sample   = '0;
            res.in_range = 1'b0;
            return res;
        end
        idx  = pos[FRAC_BITS +: IDX_BITS];
        frac = pos[FRAC_BITS-1:0];
        lo   = longint'(shadow_table[idx]);
        res.in_range = 1'b1;
        if (frac == '0)
        begin
            res.sample = SAMPLE_BITS'(lo);
        end
        else
        begin
            // A fraction is only in range below the last index, so idx + 1 exists.
            hi   = longint'(shadow_table[int'(idx) + 1]);
            prod = (hi - lo) * longint'(frac);
            res.sample = SAMPLE_BITS'(lo + (prod >>> FRAC_BITS));
        end
        return res;
    endfunction

    // Sample value weighted towards both extremes.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Position that is either negative or beyond the last valid index.
    function automatic logic signed [POS_BITS-1:0] out_of_range_position();
        logic [POS_BITS-1:0] limit;
        int unsigned         headroom;
        limit = {1'b0, shadow_last_index, {FRAC_BITS{1'b0}}};
        if ($urandom_range(0, 1) == 0)
            return {1'b1, (POS_BITS-1)'($urandom)};
        headroom = ((1 << (POS_BITS-1)) - 1) - 32'(limit);
        return POS_BITS'(32'(limit) + 1 + $urandom_range(0, headroom - 1));
    endfunction

    // Offers one item and waits for its transfer. Called and returns at a
    // falling edge; valid is left high so that a following item needs no gap.
    task automatic send_item(input logic c, input logic [IDX_BITS-1:0] addr,
                             input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic signed [POS_BITS-1:0] pos);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.cmd           <= c;
        item_bus.write_addr    <= addr;
        item_bus.write_sample  <= smp;
        item_bus.read_position <= pos;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (c == CMD_WRITE)
        begin
            shadow_table[addr]   = smp;
            shadow_written[addr] = 1'b1;
        end
        else
        begin
            pending_lookups.push_back(interpolate_lookup(pos));
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_write(input int unsigned addr, input logic signed [SAMPLE_BITS-1:0] smp);
        send_item(CMD_WRITE, IDX_BITS'(addr), smp, POS_BITS'($urandom));
    endtask

    task automatic send_read(input logic signed [POS_BITS-1:0] pos);
        send_item(CMD_READ, IDX_BITS'($urandom), SAMPLE_BITS'($urandom), pos);
    endtask

    // Stops offering items and waits until every result has come back and
    // any queued write has had time to finish.
    task automatic drain_lookups();
        item_bus.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes the last valid index while the block is idle.
    task automatic write_last_index(input logic [IDX_BITS-1:0] value);
        drain_lookups();
        cfg_bus.valid      <= 1'b1;
        cfg_bus.last_index <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        shadow_last_index = value;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Writes the neighbours of a random in-range position where needed,
    // then reads at that position.
    task automatic interpolate_sequence();
        int unsigned          idx;
        int unsigned          pick;
        logic [FRAC_BITS-1:0] frac;
        pick = $urandom_range(0, 19);
        if (pick < 4)
            frac = '0;
        else if (pick == 4)
            frac = '1;
        else if (pick == 5)
            frac = FRAC_BITS'(1);
        else
            frac = FRAC_BITS'($urandom_range(1, 65535));
        if (shadow_last_index == 0)
            frac = '0;
        idx = $urandom_range(0, shadow_last_index);
        if (frac != '0 && idx == shadow_last_index)
            idx = idx - 1;
        if (!shadow_written[idx] || $urandom_range(0, 1) == 0)
            send_write(idx, pick_sample());
        if (frac != '0 && (!shadow_written[idx + 1] || $urandom_range(0, 1) == 0))
            send_write(idx + 1, pick_sample());
        send_read({1'b0, IDX_BITS'(idx), frac});
    endtask

    // Random mix of interpolated reads, stray writes and rejected positions.
    task automatic run_traffic(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                interpolate_sequence();
            else if (pick < 85)
                send_write($urandom_range(0, TABLE_DEPTH_DEF - 1), pick_sample());
            else
                send_read(out_of_range_position());
        end
    endtask

    // Sample extremes, fraction extremes, both ends of the table and every
    // kind of rejected position at the full table length.
    task automatic test_directed_reads();
        write_last_index(12'd4095);
        send_write(0, 16'h8000);
        send_write(1, 16'h7FFF);
        send_write(2, 16'h0000);
        send_write(4094, 16'hFFFF);
        send_write(4095, 16'h1234);
        send_read(29'h0000000);
        send_read(29'h0008000);
        send_read(29'h000FFFF);
        // Falling slope: the truncation rounds towards minus infinity.
        send_read(29'h0010001);
        send_read({1'b0, 12'd4094, 16'hC000});
        send_read({1'b0, 12'd4095, 16'h0000});
        send_read({1'b0, 12'd4095, 16'h0001});
        send_read(-29'sd1);
        send_read({1'b1, 28'h0000000});
        send_read({1'b0, 28'hFFFFFFF});
        send_write(4095, 16'h8000);
        send_read({1'b0, 12'd4095, 16'h0000});
    endtask

    // Smallest settings of the last valid index and the edges around them.
    task automatic test_index_limits();
        write_last_index(12'd0);
        send_read(29'h0000000);
        send_read(29'h0000001);
        send_read(29'h0010000);
        send_read(-29'sd1);
        write_last_index(12'd1);
        send_read(29'h0004000);
        send_read(29'h0010000);
        send_read(29'h0010001);
    endtask

    // Random traffic across several table lengths, the extremes among them.
    task automatic test_mixed_traffic();
        write_last_index(12'd4095);
        run_traffic(450);
        write_last_index(IDX_BITS'($urandom_range(2, 4094)));
        run_traffic(350);
        write_last_index(IDX_BITS'($urandom_range(1, 15)));
        run_traffic(300);
        write_last_index(12'd0);
        run_traffic(60);
    endtask

    // Long stretch with neither side idling, then more traffic with random stalls.
    task automatic test_back_to_back();
        write_last_index(12'd4095);
        steady = 1'b1;
        run_traffic(250);
        drain_lookups();
        steady = 1'b0;
        run_traffic(200);
    endtask

    // Result receiver: stalls at random except during the steady stretch.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                note_failure($sformatf("unexpected result: sample %0d in_range %0b",
                                       result_bus.sample_out, result_bus.in_range));
            end
            else
            begin
                oldest_lookup = pending_lookups.pop_front();
                if (result_bus.sample_out !== oldest_lookup.sample ||
                    result_bus.in_range !== oldest_lookup.in_range)
                    note_failure($sformatf(
                        "mismatch: expected sample %0d in_range %0b, got %0d in_range %0b",
                        oldest_lookup.sample, oldest_lookup.in_range,
                        result_bus.sample_out, result_bus.in_range));
            end
        end
    end

    // Reset, then the tests in turn, then the final verdict.
    initial
    begin
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        error_count            = 0;
        items_sent             = 0;
        shadow_last_index      = LAST_INDEX_RESET;
        item_bus.valid         = 1'b0;
        item_bus.cmd           = CMD_WRITE;
        item_bus.write_addr    = '0;
        item_bus.write_sample  = '0;
        item_bus.read_position = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.last_index     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_reads();
        test_index_limits();
        test_mixed_traffic();
        test_back_to_back();

        // Let outstanding results arrive, within a bound.
        item_bus.valid <= 1'b0;
        for (int n = 0; n < END_WAIT_CYCLES && pending_lookups.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_lookups.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_lookups.size()));

        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
